@@ design/length_prefixed_message_deframer_macros.svh @@
// assertion macros for the length-prefixed message deframer
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_MACROS_SVH
`ifndef ASSERT_OFF
`define LPMD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LPMD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LPMD_ASSERT_ALWAYS(label, expr, msg)
`define LPMD_ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

@@ design/lpmd_pkg.sv @@
// shared types and constants for the length-prefixed message deframer
`default_nettype none
package lpmd_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int FIELD_BITS  = 24;

  localparam logic [FIELD_BITS-1:0] FIELD_MASK = 24'h00ffffff;
  localparam logic [FIELD_BITS-1:0] LEN_MASK =
    FIELD_BITS'(((25'(1) << LENGTH_BITS) - 25'(1))) & FIELD_MASK;
  localparam logic [FIELD_BITS-1:0] HDR_BYTES = 24'd4;

  localparam logic [FIELD_BITS-1:0] MIN_LENGTH_RST = 24'd20;
  localparam logic [FIELD_BITS-1:0] MAX_LENGTH_RST = 24'd65536;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LENGTH = 2'd1;

  // result queue: one entry in flight plus a full header release
  localparam int QDEPTH = 5;
  localparam int QCNT_BITS = 3;
  localparam int MAX_RES = 4;
  localparam int NRES_BITS = 3;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MODE_HEADER = 3'b001,
    MODE_BODY   = 3'b010,
    MODE_ERROR  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       first;
    logic       last;
    status_t    status;
  } result_t;

endpackage
`default_nettype wire

@@ design/length_prefixed_message_deframer.sv @@
// length-prefixed message deframer: header check and byte pass-through
//
// in channel: one stream byte (in_data_byte) or an abort (in_abort) per transfer,
//   valid/stall handshake; in_abort drops the partial message, gives no result
// out channel: message bytes with first/last marks and status, valid/stall
// cfg channel: valid/ready write of min_length (index 0) and max_length
//   (index 1); cfg_ready is always high, other indexes are ignored
// header bytes 0..2 are held; on header byte 3 the 24-bit length is checked
//   and either four header results or one bad-length result come out; after
//   a bad length every byte gives a dropped result until abort
// output: each result is registered into the queue and shown on out_* at its head
// throughput: one byte per cycle while in_stall is low; a header release queues four
//   results, so the input stalls after it until they drain (five-entry result queue,
//   input taken while at most one result is waiting)
// out_stall holds the queue head steady; input stalls once two results wait
// reset: framing restarts at header collection, the queue empties and the
//   length bounds return to 20 and 65536
`default_nettype none
`include "length_prefixed_message_deframer_macros.svh"
module length_prefixed_message_deframer
  import lpmd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic                    in_abort,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [7:0]                   out_out_byte,
  output logic                         out_first,
  output logic                         out_last,
  output logic [1:0]                   out_status,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [FIELD_BITS-1:0]   cfg_data
);

  logic [FIELD_BITS-1:0] min_len_r;
  logic [FIELD_BITS-1:0] max_len_r;

  mode_t                 mode_r, mode_nxt;
  logic [FIELD_BITS-1:0] held_r, held_nxt;
  logic [FIELD_BITS-1:0] count_r, count_nxt;
  logic [FIELD_BITS-1:0] msg_len_r, msg_len_nxt;

  result_t               q_r [QDEPTH];
  result_t               q_nxt [QDEPTH];
  logic [QCNT_BITS-1:0]  qcnt_r, qcnt_nxt;

  result_t               res [MAX_RES];
  logic [NRES_BITS-1:0]  n_res;
  logic                  in_fire;
  logic                  pop;
  logic [QCNT_BITS-1:0]  base;
  logic [FIELD_BITS-1:0] count_inc;
  logic [FIELD_BITS-1:0] hdr_len;
  logic                  len_bad;
  logic                  body_cnt_ok;
  logic                  hdr_cnt_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LENGTH_RST;
      max_len_r <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_LENGTH: min_len_r <= cfg_data & FIELD_MASK;
        REG_MAX_LENGTH: max_len_r <= cfg_data & FIELD_MASK;
        default: ;
      endcase
    end
  end

  assign in_stall  = (qcnt_r > QCNT_BITS'(1));
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (qcnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign base      = qcnt_r - QCNT_BITS'(pop);

  assign out_out_byte = q_r[0].out_byte;
  assign out_first    = q_r[0].first;
  assign out_last     = q_r[0].last;
  assign out_status   = q_r[0].status;

  assign count_inc = (count_r + FIELD_BITS'(1)) & FIELD_MASK;
  assign hdr_len   = {held_r[15:0], in_data_byte} & LEN_MASK;
  assign len_bad   = (hdr_len < HDR_BYTES) || (hdr_len < min_len_r) || (hdr_len > max_len_r);

  // framing state and the results of this transfer
  always_comb begin
    mode_nxt    = mode_r;
    held_nxt    = held_r;
    count_nxt   = count_r;
    msg_len_nxt = msg_len_r;
    n_res       = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '{out_byte: 8'd0, first: 1'b0, last: 1'b0, status: STATUS_OK};
    end
    if (in_fire) begin
      if (in_abort) begin
        mode_nxt    = MODE_HEADER;
        held_nxt    = '0;
        count_nxt   = '0;
        msg_len_nxt = '0;
      end else begin
        case (mode_r)
          MODE_ERROR: begin
            res[0].status = STATUS_DROPPED;
            n_res = NRES_BITS'(1);
          end
          MODE_BODY: begin
            res[0].out_byte = in_data_byte;
            res[0].last     = (count_inc >= msg_len_r);
            n_res = NRES_BITS'(1);
            if (count_inc >= msg_len_r) begin
              mode_nxt    = MODE_HEADER;
              held_nxt    = '0;
              count_nxt   = '0;
              msg_len_nxt = '0;
            end else begin
              count_nxt = count_inc;
            end
          end
          MODE_HEADER: begin
            if (count_r < HDR_BYTES - FIELD_BITS'(1)) begin
              held_nxt  = {held_r[15:0], in_data_byte} & FIELD_MASK;
              count_nxt = count_inc;
            end else if (len_bad) begin
              res[0].status = STATUS_BAD_LEN;
              n_res       = NRES_BITS'(1);
              mode_nxt    = MODE_ERROR;
              held_nxt    = '0;
              count_nxt   = '0;
              msg_len_nxt = '0;
            end else begin
              res[0].out_byte = held_r[23:16];
              res[0].first    = 1'b1;
              res[1].out_byte = held_r[15:8];
              res[2].out_byte = held_r[7:0];
              res[3].out_byte = in_data_byte;
              res[3].last     = (hdr_len == HDR_BYTES);
              n_res    = NRES_BITS'(MAX_RES);
              held_nxt = '0;
              if (hdr_len == HDR_BYTES) begin
                mode_nxt    = MODE_HEADER;
                count_nxt   = '0;
                msg_len_nxt = '0;
              end else begin
                mode_nxt    = MODE_BODY;
                count_nxt   = HDR_BYTES;
                msg_len_nxt = hdr_len;
              end
            end
          end
          default: begin
            mode_nxt    = MODE_HEADER;
            held_nxt    = '0;
            count_nxt   = '0;
            msg_len_nxt = '0;
          end
        endcase
      end
    end
  end

  // result queue: shift out the head on a transfer, append behind the rest
  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      if (pop) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    for (int k = 0; k < MAX_RES; k++) begin
      if (NRES_BITS'(k) < n_res) begin
        q_nxt[QCNT_BITS'(base + QCNT_BITS'(k))] = res[k];
      end
    end
    qcnt_nxt = base + QCNT_BITS'(n_res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HEADER;
      held_r    <= '0;
      count_r   <= '0;
      msg_len_r <= '0;
      qcnt_r    <= '0;
    end else begin
      mode_r    <= mode_nxt;
      held_r    <= held_nxt;
      count_r   <= count_nxt;
      msg_len_r <= msg_len_nxt;
      qcnt_r    <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign body_cnt_ok = (msg_len_r > HDR_BYTES) && (count_r < msg_len_r);
  assign hdr_cnt_ok  = (count_r < HDR_BYTES);

  `LPMD_ASSERT_ALWAYS(a_queue_bound, qcnt_r <= QCNT_BITS'(QDEPTH), "result queue overflow")
  `LPMD_ASSERT_IMPLIES(a_body_len, mode_r == MODE_BODY, body_cnt_ok, "body count past length")
  `LPMD_ASSERT_IMPLIES(a_header_count, mode_r != MODE_BODY, hdr_cnt_ok, "header count range")

endmodule
`default_nettype wire
